// ===== design/rrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrpm_pkg
// Shared types and constants of the rectangle mosaic block: item payloads,
// configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package rrpm_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 3'd6;

  // Reset values of the configuration registers
  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

  // Packed pixel color: red in the top byte, blue in the bottom byte
  localparam int COLOR_W = 24;
  typedef logic [COLOR_W-1:0] color_t;

  // Input item
  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic       frame_start;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       frame_end;
  } out_item_t;

endpackage

// ===== design/rrpm_ram.sv =====
// ----------------------------------------------------------------------------
// rrpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module rrpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rect_region_pixel_mosaic.sv =====
// ----------------------------------------------------------------------------
// rect_region_pixel_mosaic
// Pixelates one rectangle of a raster stream of 24-bit pixels with square
// blocks anchored at the rectangle's top-left corner.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while the output
// is not stalled and no phase realign holds in_ready low; an output register
// and one read stage separate the two sides. Block colors of the first block
// row are kept in a per-block-column RAM (MAX_WIDTH x 24) and read back on
// later rows of the block. Column and line phases advance incrementally with
// the raster position. After every configuration write the block realigns
// these phases to the current position with a bit-serial divider and holds
// in_ready low while the divider runs; configuration writes are always
// accepted.
// ----------------------------------------------------------------------------
module rect_region_pixel_mosaic #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input pixel channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rrpm_pkg::in_item_t                  in_item,
  // Result pixel channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output rrpm_pkg::out_item_t                 out_item,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import rrpm_pkg::*;

  // Position counter widths and compare widths
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int CXW = (XW + 1 > 13) ? XW + 1 : 13;
  localparam int CYW = (YW + 1 > 13) ? YW + 1 : 13;
  // Divider dividend width and step counter width
  localparam int DW  = (XW > YW) ? XW : YW;
  localparam int CNW = $clog2(DW + 1);

  // Configuration registers
  logic [11:0] image_width_r, image_height_r;
  logic [10:0] rect_left_r, rect_top_r;
  logic [11:0] rect_width_r, rect_height_r;
  logic [7:0]  block_size_r;

  // Position and phase of the next pixel
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] line_r, line_nxt;
  logic [7:0]    cph_r, cph_nxt;
  logic [7:0]    lph_r, lph_nxt;
  logic [XW-1:0] bidx_r, bidx_nxt;
  color_t        cur_color_r, cur_color_nxt;

  // Read stage and output register
  logic      s1_valid_r, s1_valid_nxt;
  color_t    s1_color_r;
  logic      s1_use_store_r;
  logic      s1_last_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // Phase realign divider
  logic           dv_start_r;
  logic           dv_busy_r;
  logic [CNW-1:0] dv_cnt_r;
  logic [DW-1:0]  dv_cd_r, dv_ld_r, dv_cq_r;
  logic [7:0]     dv_crem_r, dv_lrem_r;
  logic [8:0]     dv_ctrial, dv_ltrial;
  logic           dv_cbit, dv_lbit;
  logic [7:0]     dv_crem_nxt, dv_lrem_nxt;
  logic [DW-1:0]  dv_cq_nxt;
  logic           dv_active;

  // Stage 0 signals
  logic          in_acc, s1_adv;
  logic          fs;
  color_t        pix;
  logic [CXW-1:0] w_c, col_c, col_p1, x1_c;
  logic [CYW-1:0] h_c, line_c, line_p1, y1_c;
  logic [7:0]    cph_cur, lph_cur;
  logic [XW-1:0] bidx_cur;
  logic [YW-1:0] line_adv;
  logic          col_wrap, line_wrap;
  logic          in_x, in_y, mos, top_row, corner;
  logic          ram_wr, ram_rd, use_store;
  color_t        color0;
  logic [8:0]    cph_inc, lph_inc;
  color_t        ram_rd_data;

  // Handshake
  assign dv_active = dv_start_r | dv_busy_r;
  assign s1_adv    = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~dv_active & (~s1_valid_r | s1_adv);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      rect_left_r    <= '0;
      rect_top_r     <= '0;
      rect_width_r   <= '0;
      rect_height_r  <= '0;
      block_size_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_RECT_LEFT:    rect_left_r    <= cfg_data[10:0];
        CFG_RECT_TOP:     rect_top_r     <= cfg_data[10:0];
        CFG_RECT_WIDTH:   rect_width_r   <= cfg_data;
        CFG_RECT_HEIGHT:  rect_height_r  <= cfg_data;
        CFG_BLOCK_SIZE:   block_size_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Clamped image size and clipped rectangle edges
  always_comb begin
    if (image_width_r == '0) begin
      w_c = CXW'(1);
    end else if (CXW'(image_width_r) > CXW'(MAX_WIDTH)) begin
      w_c = CXW'(MAX_WIDTH);
    end else begin
      w_c = CXW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_c = CYW'(1);
    end else if (CYW'(image_height_r) > CYW'(MAX_HEIGHT)) begin
      h_c = CYW'(MAX_HEIGHT);
    end else begin
      h_c = CYW'(image_height_r);
    end
    x1_c = CXW'(rect_left_r) + CXW'(rect_width_r);
    if (x1_c > w_c) begin
      x1_c = w_c;
    end
    y1_c = CYW'(rect_top_r) + CYW'(rect_height_r);
    if (y1_c > h_c) begin
      y1_c = h_c;
    end
  end

  // Stage 0: position, block decision and store access
  always_comb begin
    fs  = in_item.frame_start;
    pix = {in_item.in_red, in_item.in_green, in_item.in_blue};

    // frame start places this pixel at the origin
    col_c    = fs ? '0 : CXW'(col_r);
    line_c   = fs ? '0 : CYW'(line_r);
    cph_cur  = fs ? '0 : cph_r;
    lph_cur  = fs ? '0 : lph_r;
    bidx_cur = fs ? '0 : bidx_r;

    in_x = (col_c >= CXW'(rect_left_r)) && (col_c < x1_c);
    in_y = (line_c >= CYW'(rect_top_r)) && (line_c < y1_c);
    mos  = (block_size_r != '0) && in_x && in_y;

    top_row = (lph_cur == '0);
    corner  = top_row && (cph_cur == '0);

    ram_wr    = in_acc && mos && corner;
    use_store = mos && !top_row;
    ram_rd    = in_acc && use_store;

    cur_color_nxt = ram_wr ? pix : cur_color_r;
    if (mos && top_row) begin
      color0 = corner ? pix : cur_color_r;
    end else begin
      color0 = pix;
    end

    // raster advance
    col_p1    = col_c + CXW'(1);
    line_p1   = line_c + CYW'(1);
    col_wrap  = (col_p1 >= w_c);
    line_wrap = (line_p1 >= h_c);
    line_adv  = line_wrap ? '0 : line_p1[YW-1:0];

    // phases of the next pixel
    cph_inc = {1'b0, cph_cur} + 9'd1;
    lph_inc = {1'b0, lph_cur} + 9'd1;

    col_nxt  = col_r;
    line_nxt = line_r;
    cph_nxt  = cph_r;
    bidx_nxt = bidx_r;
    lph_nxt  = lph_r;
    if (in_acc) begin
      if (col_wrap) begin
        col_nxt  = '0;
        cph_nxt  = '0;
        bidx_nxt = '0;
        line_nxt = line_adv;
        if (CYW'(line_adv) == CYW'(rect_top_r)) begin
          lph_nxt = '0;
        end else if (lph_inc == {1'b0, block_size_r}) begin
          lph_nxt = '0;
        end else begin
          lph_nxt = lph_inc[7:0];
        end
      end else begin
        col_nxt  = col_p1[XW-1:0];
        line_nxt = line_c[YW-1:0];
        lph_nxt  = lph_cur;
        if (col_p1 == CXW'(rect_left_r)) begin
          cph_nxt  = '0;
          bidx_nxt = '0;
        end else if (cph_inc == {1'b0, block_size_r}) begin
          cph_nxt  = '0;
          bidx_nxt = bidx_cur + XW'(1);
        end else begin
          cph_nxt  = cph_inc[7:0];
          bidx_nxt = bidx_cur;
        end
      end
    end else if (dv_busy_r && dv_cnt_r == CNW'(1)) begin
      // realign phases to the current position
      cph_nxt  = dv_crem_nxt;
      bidx_nxt = dv_cq_nxt[XW-1:0];
      lph_nxt  = dv_lrem_nxt;
    end
  end

  // Bit-serial restoring divide of the position offsets by the block size
  always_comb begin
    dv_ctrial = {dv_crem_r, dv_cd_r[DW-1]};
    dv_ltrial = {dv_lrem_r, dv_ld_r[DW-1]};
    dv_cbit   = (dv_ctrial >= {1'b0, block_size_r});
    dv_lbit   = (dv_ltrial >= {1'b0, block_size_r});
    dv_crem_nxt = dv_cbit ? 8'(dv_ctrial - {1'b0, block_size_r}) : dv_ctrial[7:0];
    dv_lrem_nxt = dv_lbit ? 8'(dv_ltrial - {1'b0, block_size_r}) : dv_ltrial[7:0];
    dv_cq_nxt   = {dv_cq_r[DW-2:0], dv_cbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_start_r <= 1'b0;
      dv_busy_r  <= 1'b0;
      dv_cnt_r   <= '0;
    end else begin
      dv_start_r <= cfg_valid & cfg_ready;
      if (dv_start_r) begin
        dv_busy_r <= 1'b1;
        dv_cnt_r  <= CNW'(DW);
      end else if (dv_busy_r) begin
        dv_cnt_r <= dv_cnt_r - CNW'(1);
        if (dv_cnt_r == CNW'(1)) begin
          dv_busy_r <= 1'b0;
        end
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (dv_start_r) begin
      dv_cd_r   <= DW'(CXW'(col_r) - CXW'(rect_left_r));
      dv_ld_r   <= DW'(CYW'(line_r) - CYW'(rect_top_r));
      dv_cq_r   <= '0;
      dv_crem_r <= '0;
      dv_lrem_r <= '0;
    end else if (dv_busy_r) begin
      dv_cd_r   <= {dv_cd_r[DW-2:0], 1'b0};
      dv_ld_r   <= {dv_ld_r[DW-2:0], 1'b0};
      dv_cq_r   <= dv_cq_nxt;
      dv_crem_r <= dv_crem_nxt;
      dv_lrem_r <= dv_lrem_nxt;
    end
  end

  // Position, phase and block color state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      cph_r       <= '0;
      lph_r       <= '0;
      bidx_r      <= '0;
      cur_color_r <= '0;
    end else begin
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      cph_r       <= cph_nxt;
      lph_r       <= lph_nxt;
      bidx_r      <= bidx_nxt;
      cur_color_r <= cur_color_nxt;
    end
  end

  // Per-block-column color store
  rrpm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_WIDTH)
  ) u_color_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (bidx_cur),
    .wr_data (pix),
    .rd_en   (ram_rd),
    .rd_addr (bidx_cur),
    .rd_data (ram_rd_data)
  );

  // Read stage and output register control
  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_color_r     <= color0;
      s1_use_store_r <= use_store;
      s1_last_r      <= col_wrap & line_wrap;
    end
  end

  // Output payload: stored block color on later block rows
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_use_store_r) begin
        out_item_r.out_red   <= ram_rd_data[23:16];
        out_item_r.out_green <= ram_rd_data[15:8];
        out_item_r.out_blue  <= ram_rd_data[7:0];
      end else begin
        out_item_r.out_red   <= s1_color_r[23:16];
        out_item_r.out_green <= s1_color_r[15:8];
        out_item_r.out_blue  <= s1_color_r[7:0];
      end
      out_item_r.frame_end <= s1_last_r;
    end
  end

endmodule
